[rtl/rhsv_pkg.sv]
// ----------------------------------------------------------------------------
// rhsv_pkg
// Shared widths, constants and types for the RGB to HSV converter pipeline.
// ----------------------------------------------------------------------------
package rhsv_pkg;

    localparam int COMP_W = 8;    // colour channel width
    localparam int HUE_W  = 9;    // hue, 0..359
    localparam int PCT_W  = 7;    // saturation / brightness percent
    localparam int NUM_W  = 15;   // dividend width, holds 100*255
    localparam int QUO_W  = 7;    // quotient width, both quotients stay below 128

    localparam int DIV_STAGES   = QUO_W;
    localparam int FRONT_STAGES = 2;
    localparam int BACK_STAGES  = 1;
    localparam int PIPE_LATENCY = FRONT_STAGES + DIV_STAGES + BACK_STAGES;

    localparam logic [NUM_W-1:0] HUE_SCALE = NUM_W'(60);
    localparam logic [NUM_W-1:0] PCT_SCALE = NUM_W'(100);

    localparam logic [HUE_W-1:0] HUE_FULL  = HUE_W'(360);
    localparam logic [HUE_W-1:0] HUE_GREEN = HUE_W'(120);
    localparam logic [HUE_W-1:0] HUE_BLUE  = HUE_W'(240);

    typedef enum logic [1:0] {
        SECT_RED,
        SECT_GREEN,
        SECT_BLUE
    } sector_t;

    // Per-pixel information carried alongside the divider lanes
    typedef struct packed {
        sector_t          sector;
        logic             neg;
        logic             gray;
        logic [PCT_W-1:0] val;
    } side_t;

    // Hue lane divides by the channel span, saturation lane by the maximum
    typedef struct packed {
        logic [NUM_W-1:0]  num_h;
        logic [NUM_W-1:0]  num_s;
        logic [COMP_W-1:0] den_h;
        logic [COMP_W-1:0] den_s;
        side_t             side;
    } div_req_t;

    typedef struct packed {
        logic [QUO_W-1:0] quo_h;
        logic             rem_h_nz;
        logic [QUO_W-1:0] quo_s;
        side_t            side;
    } div_rsp_t;

endpackage

[rtl/rhsv_front.sv]
// ----------------------------------------------------------------------------
// rhsv_front
// Two stages: channel max/min and sector select, then the scaling multiplies.
// ----------------------------------------------------------------------------
module rhsv_front
    import rhsv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [COMP_W-1:0] red,
    input  logic [COMP_W-1:0] green,
    input  logic [COMP_W-1:0] blue,
    output logic              out_valid,
    output div_req_t          out_req
);

    logic [COMP_W-1:0] mx_next, mn_next, mag_next;
    sector_t           sector_next;
    logic              neg_next;

    logic              v1_reg;
    logic [COMP_W-1:0] mx_reg, d_reg, mag_reg;
    sector_t           sector_reg;
    logic              neg_reg;

    logic              v2_reg;
    div_req_t          req_reg;
    div_req_t          req_next;
    logic [NUM_W-1:0]  prod_v;

    always_comb
    begin
        mx_next = red;
        mn_next = red;
        if (green > mx_next) mx_next = green;
        if (blue  > mx_next) mx_next = blue;
        if (green < mn_next) mn_next = green;
        if (blue  < mn_next) mn_next = blue;

        // Red wins ties, then green
        if (red >= green && red >= blue)
        begin
            sector_next = SECT_RED;
            neg_next    = green < blue;
            mag_next    = neg_next ? (blue - green) : (green - blue);
        end
        else if (green >= blue)
        begin
            sector_next = SECT_GREEN;
            neg_next    = blue < red;
            mag_next    = neg_next ? (red - blue) : (blue - red);
        end
        else
        begin
            sector_next = SECT_BLUE;
            neg_next    = red < green;
            mag_next    = neg_next ? (green - red) : (red - green);
        end
    end

    always_comb
    begin
        prod_v             = NUM_W'(mx_reg) * PCT_SCALE;
        req_next.num_h     = NUM_W'(mag_reg) * HUE_SCALE;
        req_next.num_s     = NUM_W'(d_reg) * PCT_SCALE;
        req_next.den_h     = d_reg;
        req_next.den_s     = mx_reg;
        req_next.side.sector = sector_reg;
        req_next.side.neg  = neg_reg;
        req_next.side.gray = (d_reg == '0);
        req_next.side.val  = prod_v[NUM_W-1:NUM_W-PCT_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mx_reg     <= mx_next;
        d_reg      <= mx_next - mn_next;
        mag_reg    <= mag_next;
        sector_reg <= sector_next;
        neg_reg    <= neg_next;
        req_reg    <= req_next;
    end

    assign out_valid = v2_reg;
    assign out_req   = req_reg;

endmodule

[rtl/rhsv_div.sv]
// ----------------------------------------------------------------------------
// rhsv_div
// Pipelined restoring divider, one quotient bit per stage, two lanes: hue
// fraction over the channel span and saturation over the channel maximum.
// ----------------------------------------------------------------------------
module rhsv_div
    import rhsv_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  div_req_t in_req,
    output logic     out_valid,
    output div_rsp_t out_rsp
);

    // Stage inputs: the request for the first stage, the previous registers after
    logic              valid_in [DIV_STAGES];
    logic [NUM_W-1:0]  rem_h_in [DIV_STAGES];
    logic [NUM_W-1:0]  rem_s_in [DIV_STAGES];
    logic [QUO_W-1:0]  quo_h_in [DIV_STAGES];
    logic [QUO_W-1:0]  quo_s_in [DIV_STAGES];
    logic [COMP_W-1:0] den_h_in [DIV_STAGES];
    logic [COMP_W-1:0] den_s_in [DIV_STAGES];
    side_t             side_in  [DIV_STAGES];

    logic              valid_reg [DIV_STAGES];
    logic [NUM_W-1:0]  rem_h_reg [DIV_STAGES];
    logic [QUO_W-1:0]  quo_h_reg [DIV_STAGES];
    logic [QUO_W-1:0]  quo_s_reg [DIV_STAGES];
    side_t             side_reg  [DIV_STAGES];
    logic [NUM_W-1:0]  rem_s_reg [DIV_STAGES-1];
    logic [COMP_W-1:0] den_h_reg [DIV_STAGES-1];
    logic [COMP_W-1:0] den_s_reg [DIV_STAGES-1];

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_stage
        localparam int BIT = QUO_W - 1 - k;

        logic [NUM_W-1:0] trial_h, trial_s;
        logic             take_h, take_s;
        logic [NUM_W-1:0] rem_h_next, rem_s_next;
        logic [QUO_W-1:0] quo_h_next, quo_s_next;

        if (k == 0)
        begin : g_head
            assign valid_in[k] = in_valid;
            assign rem_h_in[k] = in_req.num_h;
            assign rem_s_in[k] = in_req.num_s;
            assign quo_h_in[k] = '0;
            assign quo_s_in[k] = '0;
            assign den_h_in[k] = in_req.den_h;
            assign den_s_in[k] = in_req.den_s;
            assign side_in[k]  = in_req.side;
        end
        else
        begin : g_link
            assign valid_in[k] = valid_reg[k-1];
            assign rem_h_in[k] = rem_h_reg[k-1];
            assign rem_s_in[k] = rem_s_reg[k-1];
            assign quo_h_in[k] = quo_h_reg[k-1];
            assign quo_s_in[k] = quo_s_reg[k-1];
            assign den_h_in[k] = den_h_reg[k-1];
            assign den_s_in[k] = den_s_reg[k-1];
            assign side_in[k]  = side_reg[k-1];
        end

        always_comb
        begin
            trial_h    = NUM_W'(den_h_in[k]) << BIT;
            trial_s    = NUM_W'(den_s_in[k]) << BIT;
            take_h     = rem_h_in[k] >= trial_h;
            take_s     = rem_s_in[k] >= trial_s;
            rem_h_next = take_h ? (rem_h_in[k] - trial_h) : rem_h_in[k];
            rem_s_next = take_s ? (rem_s_in[k] - trial_s) : rem_s_in[k];
            quo_h_next = quo_h_in[k];
            quo_s_next = quo_s_in[k];
            quo_h_next[BIT] = take_h;
            quo_s_next[BIT] = take_s;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= valid_in[k];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_h_reg[k] <= rem_h_next;
            quo_h_reg[k] <= quo_h_next;
            quo_s_reg[k] <= quo_s_next;
            side_reg[k]  <= side_in[k];
        end

        // Divisors and the saturation remainder are only needed by later stages
        if (k < DIV_STAGES - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                rem_s_reg[k] <= rem_s_next;
                den_h_reg[k] <= den_h_in[k];
                den_s_reg[k] <= den_s_in[k];
            end
        end
    end

    assign out_valid        = valid_reg[DIV_STAGES-1];
    assign out_rsp.quo_h    = quo_h_reg[DIV_STAGES-1];
    assign out_rsp.rem_h_nz = (rem_h_reg[DIV_STAGES-1] != '0);
    assign out_rsp.quo_s    = quo_s_reg[DIV_STAGES-1];
    assign out_rsp.side     = side_reg[DIV_STAGES-1];

endmodule

[rtl/rhsv_back.sv]
// ----------------------------------------------------------------------------
// rhsv_back
// Final stage: fold quotient and sector into hue, gate gray pixels, register
// the result beat.
// ----------------------------------------------------------------------------
module rhsv_back
    import rhsv_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  div_rsp_t         in_rsp,
    output logic             done,
    output logic [HUE_W-1:0] hue,
    output logic [PCT_W-1:0] saturation,
    output logic [PCT_W-1:0] brightness
);

    logic [HUE_W-1:0] q_v;
    logic [HUE_W-1:0] up_v;
    logic [HUE_W-1:0] hue_next;
    logic [PCT_W-1:0] sat_next;

    logic             done_reg;
    logic [HUE_W-1:0] hue_reg;
    logic [PCT_W-1:0] sat_reg;
    logic [PCT_W-1:0] val_reg;

    always_comb
    begin
        q_v  = HUE_W'(in_rsp.quo_h);
        // Floor of a negative fraction rounds away from zero
        up_v = q_v + HUE_W'(in_rsp.rem_h_nz);
        case (in_rsp.side.sector)
            SECT_RED:
            begin
                // Truncated toward zero, wrap negatives into 300..359
                hue_next = (in_rsp.side.neg && q_v != '0) ? (HUE_FULL - q_v) : q_v;
            end
            SECT_GREEN:
            begin
                hue_next = in_rsp.side.neg ? (HUE_GREEN - up_v) : (HUE_GREEN + q_v);
            end
            SECT_BLUE:
            begin
                hue_next = in_rsp.side.neg ? (HUE_BLUE - up_v) : (HUE_BLUE + q_v);
            end
            default:
            begin
                hue_next = '0;
            end
        endcase
        sat_next = in_rsp.quo_s;
        if (in_rsp.side.gray)
        begin
            hue_next = '0;
            sat_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        hue_reg <= hue_next;
        sat_reg <= sat_next;
        val_reg <= in_rsp.side.val;
    end

    assign done       = done_reg;
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign brightness = val_reg;

endmodule

[rtl/rgb_to_hsv_converter_top.sv]
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_top
// RGB pixel to hue / saturation / value converter, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one pixel on every cycle that start is high; busy is always low. Each
// pixel gives one result beat, marked by done for one cycle, once it has
// passed two front stages (max/min, then the scaling multiplies), seven
// divider stages that each settle one quotient bit, and one output stage.
// Results come out in input order and cannot be held off, so the receiver
// must take done beats as they arrive.
module rgb_to_hsv_converter_top
    import rhsv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [COMP_W-1:0] red,
    input  logic [COMP_W-1:0] green,
    input  logic [COMP_W-1:0] blue,
    output logic              done,
    output logic [HUE_W-1:0]  hue,
    output logic [PCT_W-1:0]  saturation,
    output logic [PCT_W-1:0]  brightness
);

    logic     front_valid;
    div_req_t front_req;
    logic     div_valid;
    div_rsp_t div_rsp;

    // Every stage advances each cycle, so a new pixel is always welcome
    assign busy = 1'b0;

    rhsv_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .out_valid (front_valid),
        .out_req   (front_req)
    );

    rhsv_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_req    (front_req),
        .out_valid (div_valid),
        .out_rsp   (div_rsp)
    );

    rhsv_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (div_valid),
        .in_rsp     (div_rsp),
        .done       (done),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness)
    );

endmodule

[rtl/rhsv_checker.sv]
// ----------------------------------------------------------------------------
// rhsv_checker
// Port-level checks on the converter: latency, result ranges, gray pixels.
// ----------------------------------------------------------------------------
module rhsv_checker
    import rhsv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic [COMP_W-1:0] red,
    input  logic [COMP_W-1:0] green,
    input  logic [COMP_W-1:0] blue,
    input  logic              done,
    input  logic [HUE_W-1:0]  hue,
    input  logic [PCT_W-1:0]  saturation,
    input  logic [PCT_W-1:0]  brightness
);

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    a_beat_out: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##PIPE_LATENCY done)
        else $error("accepted pixel gave no result beat");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, PIPE_LATENCY))
        else $error("result beat without a pixel");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (hue <= HUE_W'(359) && saturation <= PCT_W'(100)
                  && brightness <= PCT_W'(99)))
        else $error("result field out of range");

    a_gray: assert property (@(posedge clk) disable iff (!rst_n)
        (start && red == green && green == blue)
        |-> ##PIPE_LATENCY (hue == '0 && saturation == '0))
        else $error("gray pixel gave nonzero hue or saturation");

endmodule

bind rgb_to_hsv_converter_top rhsv_checker u_rhsv_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .done       (done),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness)
);

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Checks the RGB to HSV converter beat by beat against an integer predictor.
// Directed corner pixels come first, then random pixels in back-to-back bursts,
// with random sender gaps, and pixels whose channels are nearly equal. One
// pause lets the pipeline drain completely before the run continues.
// ----------------------------------------------------------------------------
module testbench;
    import rhsv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [HUE_W-1:0] hue;
        logic [PCT_W-1:0] sat;
        logic [PCT_W-1:0] bright;
    } hsv_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
    logic              done;
    logic [HUE_W-1:0]  hue;
    logic [PCT_W-1:0]  saturation;
    logic [PCT_W-1:0]  brightness;

    hsv_t pending_hsv[$];
    int   mismatches = 0;

    rgb_to_hsv_converter_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .done       (done),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness)
    );

    always #5 clk = ~clk;

    // Round towards minus infinity, den > 0
    function automatic int floor_quot(int num, int den);
        if (num >= 0)
            return num / den;
        return -((-num + den - 1) / den);
    endfunction

    function automatic hsv_t predict_hsv(logic [COMP_W-1:0] r, logic [COMP_W-1:0] g,
                                         logic [COMP_W-1:0] b);
        int   rr;
        int   gg;
        int   bb;
        int   top;
        int   bot;
        int   span;
        int   h;
        int   s;
        int   v;
        hsv_t res;
        rr  = int'(r);
        gg  = int'(g);
        bb  = int'(b);
        top = rr;
        bot = rr;
        if (gg > top) top = gg;
        if (bb > top) top = bb;
        if (gg < bot) bot = gg;
        if (bb < bot) bot = bb;
        span = top - bot;
        v    = (top * 100) / 256;
        h    = 0;
        s    = 0;
        if (span != 0)
        begin
            // red wins ties and truncates; the other sectors round down
            if (top == rr)
            begin
                h = (60 * (gg - bb)) / span;
                if (h < 0)
                    h += 360;
            end
            else if (top == gg)
                h = 120 + floor_quot(60 * (bb - rr), span);
            else
                h = 240 + floor_quot(60 * (rr - gg), span);
            s = (span * 100) / top;
        end
        res.hue    = h[HUE_W-1:0];
        res.sat    = s[PCT_W-1:0];
        res.bright = v[PCT_W-1:0];
        return res;
    endfunction

    task automatic compare_field(string field, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    // Take each result beat and match it against the oldest prediction
    always @(posedge clk)
    begin : check_beats
        hsv_t want;
        if (rst_n && done)
        begin
            if (pending_hsv.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, actual hue %0d sat %0d val %0d",
                         $time, hue, saturation, brightness);
                mismatches++;
            end
            else
            begin
                want = pending_hsv.pop_front();
                compare_field("hue", want.hue, hue);
                compare_field("saturation", want.sat, saturation);
                compare_field("brightness", want.bright, brightness);
            end
        end
    end

    // Hold start low with noise on the channels for the given gap, then offer the pixel
    task automatic send_pixel(logic [COMP_W-1:0] r, logic [COMP_W-1:0] g,
                              logic [COMP_W-1:0] b, int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap)
            begin
                red   <= COMP_W'($urandom);
                green <= COMP_W'($urandom);
                blue  <= COMP_W'($urandom);
                @(posedge clk);
            end
        end
        start <= 1'b1;
        red   <= r;
        green <= g;
        blue  <= b;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        pending_hsv.push_back(predict_hsv(r, g, b));
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_hsv.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 4) @(posedge clk);
    endtask

    function automatic int draw_gap(bit bursty);
        if (bursty || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 15);
    endfunction

    task automatic test_corner_pixels();
        send_pixel(8'd0,   8'd0,   8'd0,   0);
        send_pixel(8'd255, 8'd255, 8'd255, 0);
        send_pixel(8'd100, 8'd100, 8'd100, 3);
        send_pixel(8'd255, 8'd0,   8'd0,   0);
        send_pixel(8'd0,   8'd255, 8'd0,   1);
        send_pixel(8'd0,   8'd0,   8'd255, 0);
        send_pixel(8'd255, 8'd255, 8'd0,   0);   // red ties green
        send_pixel(8'd255, 8'd0,   8'd255, 2);   // red ties blue, wraps to 300
        send_pixel(8'd0,   8'd255, 8'd255, 0);   // green ties blue
        send_pixel(8'd255, 8'd0,   8'd1,   0);   // truncates to zero, no wrap
        send_pixel(8'd255, 8'd1,   8'd0,   0);
        send_pixel(8'd255, 8'd0,   8'd2,   5);
        send_pixel(8'd1,   8'd255, 8'd0,   0);   // rounds down below 120
        send_pixel(8'd0,   8'd1,   8'd255, 0);   // rounds down below 240
        send_pixel(8'd1,   8'd0,   8'd0,   0);   // full saturation, zero value
        send_pixel(8'd1,   8'd1,   8'd0,   0);
        send_pixel(8'd1,   8'd0,   8'd1,   7);
        send_pixel(8'd0,   8'd1,   8'd1,   0);
        send_pixel(8'd128, 8'd128, 8'd127, 0);
        send_pixel(8'd254, 8'd255, 8'd253, 0);
        send_pixel(8'd3,   8'd2,   8'd255, 15);
        send_pixel(8'd170, 8'd85,  8'd0,   0);
    endtask

    task automatic test_random_bursts(int count);
        repeat (count)
            send_pixel(COMP_W'($urandom), COMP_W'($urandom), COMP_W'($urandom), 0);
    endtask

    task automatic test_random_gaps(int count);
        bit bursty;
        bursty = 1'b0;
        repeat (count)
        begin
            // switch between bursts and gappy stretches now and then
            if ($urandom_range(0, 31) == 0)
                bursty = ~bursty;
            send_pixel(COMP_W'($urandom), COMP_W'($urandom), COMP_W'($urandom),
                       draw_gap(bursty));
        end
    endtask

    // Channels close together: small spans, ties and sector boundaries
    task automatic test_near_gray(int count);
        int top;
        int spread;
        int ch[3];
        repeat (count)
        begin
            top    = $urandom_range(0, 255);
            spread = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 3);
            foreach (ch[i])
            begin
                ch[i] = top - $urandom_range(0, spread);
                if (ch[i] < 0)
                    ch[i] = 0;
            end
            ch[$urandom_range(0, 2)] = top;
            send_pixel(COMP_W'(ch[0]), COMP_W'(ch[1]), COMP_W'(ch[2]), draw_gap(1'b0));
        end
    endtask

    initial
    begin
        clk   = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        red   = '0;
        green = '0;
        blue  = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corner_pixels();
        test_random_bursts(600);
        drain_results();
        test_random_gaps(800);
        test_near_gray(480);
        drain_results();

        if (mismatches == 0 && pending_hsv.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
